/* rtl/ticc_pkg.sv */
package ticc_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned DimW   = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned SelW   = 3;
  localparam int unsigned BitCntW = 6;

  // Register map: one 64-bit register per 8-byte slot, selected by paddr[3]
  localparam logic RegShapeRank = 1'b0;
  localparam logic RegDimSizes  = 1'b1;

  localparam logic ModeToIndex  = 1'b0;
  localparam logic ModeToCoords = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDiv,
    StFinish
  } ticc_state_e;

  typedef struct packed {
    logic            load;
    logic            load_mode;
    logic            mac_step;
    logic            div_step;
    logic            div_last;
    logic [SelW-1:0] sel;
    logic            out_load;
    logic            out_mode;
    logic [CntW-1:0] out_cnt;
  } ticc_cmd_t;

endpackage

/* rtl/ticc_dp.sv */
module ticc_dp
  import ticc_pkg::*;
(
  input  logic              clk_i,
  input  ticc_cmd_t         cmd_i,
  input  logic [DataW-1:0]  dimension_sizes_i,
  input  logic [DataW-1:0]  coordinates_in_i,
  input  logic [DataW-1:0]  linear_index_in_i,
  output logic [DataW-1:0]  linear_index_out_o,
  output logic [DataW-1:0]  coordinates_out_o,
  output logic [CntW-1:0]   coordinate_count_out_o
);

  logic [DataW-1:0]   coords_src_q, coords_src_d;
  logic [DataW-1:0]   acc_q, acc_d;
  logic [DimW-1:0]    rem_q, rem_d;
  logic [DataW-1:0]   coords_q, coords_d;
  logic [DataW-1:0]   lin_out_q, lin_out_d;
  logic [DataW-1:0]   coords_out_q, coords_out_d;
  logic [CntW-1:0]    cnt_out_q, cnt_out_d;

  logic [DimW-1:0]    dim_raw;
  logic [DimW-1:0]    dim;
  logic [DimW-1:0]    coord_byte;
  logic [DataW+DimW-1:0] product;
  logic [DataW-1:0]   mac_sum;
  logic [DimW:0]      rem_sh;
  logic               rem_ge;
  logic [DimW:0]      rem_diff;
  logic [DimW-1:0]    rem_new;

  assign dim_raw    = dimension_sizes_i[cmd_i.sel*DimW +: DimW];
  assign dim        = (dim_raw == '0) ? DimW'(1) : dim_raw;
  assign coord_byte = coords_src_q[cmd_i.sel*DimW +: DimW];

  // Horner step: acc * dim + coordinate, wrapping at the data width
  assign product = acc_q * dim;
  assign mac_sum = product[DataW-1:0] + DataW'(coord_byte);

  // Restoring radix-2 division step: quotient bits shift into acc from the bottom
  assign rem_sh   = {rem_q, acc_q[DataW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, dim});
  assign rem_diff = rem_sh - {1'b0, dim};
  assign rem_new  = rem_ge ? rem_diff[DimW-1:0] : rem_sh[DimW-1:0];

  always_comb begin
    coords_src_d = coords_src_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    coords_d     = coords_q;
    if (cmd_i.load) begin
      coords_src_d = coordinates_in_i;
      acc_d        = (cmd_i.load_mode == ModeToCoords) ? linear_index_in_i : '0;
      rem_d        = '0;
      coords_d     = '0;
    end else if (cmd_i.mac_step) begin
      acc_d = mac_sum;
    end else if (cmd_i.div_step) begin
      acc_d = {acc_q[DataW-2:0], rem_ge};
      if (cmd_i.div_last) begin
        coords_d[cmd_i.sel*DimW +: DimW] = rem_new;
        rem_d = '0;
      end else begin
        rem_d = rem_new;
      end
    end
  end

  always_comb begin
    lin_out_d    = lin_out_q;
    coords_out_d = coords_out_q;
    cnt_out_d    = cnt_out_q;
    if (cmd_i.out_load) begin
      lin_out_d    = (cmd_i.out_mode == ModeToIndex) ? acc_q : '0;
      coords_out_d = (cmd_i.out_mode == ModeToCoords) ? coords_q : '0;
      cnt_out_d    = cmd_i.out_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    coords_src_q <= coords_src_d;
    acc_q        <= acc_d;
    rem_q        <= rem_d;
    coords_q     <= coords_d;
    lin_out_q    <= lin_out_d;
    coords_out_q <= coords_out_d;
    cnt_out_q    <= cnt_out_d;
  end

  assign linear_index_out_o     = lin_out_q;
  assign coordinates_out_o      = coords_out_q;
  assign coordinate_count_out_o = cnt_out_q;

endmodule

/* rtl/ticc_ctrl.sv */
module ticc_ctrl
  import ticc_pkg::*;
#(
  parameter int unsigned MAX_RANK = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  logic [CntW-1:0] coordinate_count_i,
  input  logic [CntW-1:0] shape_rank_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ticc_cmd_t       cmd_o
);

  localparam logic [CntW-1:0] MaxRank = CntW'(MAX_RANK);

  ticc_state_e         state_q, state_d;
  logic                mode_q, mode_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [BitCntW-1:0]  bit_q, bit_d;
  logic                out_valid_q, out_valid_d;

  logic                accept;
  logic                out_free;
  logic [CntW-1:0]     rank_eff;
  logic [CntW-1:0]     count_eff;
  logic [CntW-1:0]     n_use;
  logic [CntW-1:0]     k_dec;

  assign rank_eff  = (shape_rank_i > MaxRank) ? MaxRank : shape_rank_i;
  assign count_eff = (coordinate_count_i > MaxRank) ? MaxRank : coordinate_count_i;
  assign n_use     = (rank_eff < count_eff) ? rank_eff : count_eff;
  assign k_dec     = k_q - CntW'(1);

  assign accept   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (mode_i == ModeToCoords) ? StDiv : StMac;
        end
      end
      StMac: begin
        if (k_q == '0) begin
          state_d = StFinish;
        end
      end
      StDiv: begin
        if (k_q == n_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs and counters
  always_comb begin
    cmd_o    = '0;
    mode_d   = mode_q;
    n_d      = n_q;
    k_d      = k_q;
    bit_d    = bit_q;
    cmd_o.out_mode = mode_q;
    cmd_o.out_cnt  = (mode_q == ModeToCoords) ? n_q : '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load      = 1'b1;
          cmd_o.load_mode = mode_i;
          mode_d          = mode_i;
          bit_d           = '0;
          if (mode_i == ModeToCoords) begin
            n_d = rank_eff;
            k_d = '0;
          end else begin
            n_d = n_use;
            k_d = n_use;
          end
        end
      end
      StMac: begin
        cmd_o.sel = k_dec[SelW-1:0];
        if (k_q != '0) begin
          cmd_o.mac_step = 1'b1;
          k_d            = k_dec;
        end
      end
      StDiv: begin
        cmd_o.sel = k_q[SelW-1:0];
        if (k_q != n_q) begin
          cmd_o.div_step = 1'b1;
          cmd_o.div_last = &bit_q;
          bit_d          = bit_q + BitCntW'(1);
          if (&bit_q) begin
            k_d = k_q + CntW'(1);
          end
        end
      end
      StFinish: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      n_q         <= n_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/tensor_index_coordinate_converter.sv */
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  mode, coordinates_in, coordinate_count,
//                                              linear_index_in
// output    out        out_valid_o/out_stall_i linear_index_out, coordinates_out,
//                                              coordinate_count_out
// config    in         APB (psel/penable)     shape_rank @0x0, dimension_sizes @0x8
//
// Mode 0 folds n = min(rank, count) coordinates after acceptance: one Horner
// multiply-add per cycle. Mode 1 splits the index into rank coordinates after acceptance:
// each dimension runs 64 steps on the radix-2 divider. The result then goes to the output
// register once it is free; a stalled output register holds the item back until it is.
// The next beat is taken once the result sits in the output register, even while stalled.
// Reset clears control state, sets rank to 0 and every dimension size to 1.
module tensor_index_coordinate_converter
  import ticc_pkg::*;
#(
  parameter int unsigned MAX_RANK = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  logic [DataW-1:0] coordinates_in_i,
  input  logic [CntW-1:0]  coordinate_count_i,
  input  logic [DataW-1:0] linear_index_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] linear_index_out_o,
  output logic [DataW-1:0] coordinates_out_o,
  output logic [CntW-1:0]  coordinate_count_out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [CntW-1:0]  shape_rank_q, shape_rank_d;
  logic [DataW-1:0] dim_sizes_q, dim_sizes_d;
  logic             cfg_write;
  ticc_cmd_t        cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    shape_rank_d = shape_rank_q;
    dim_sizes_d  = dim_sizes_q;
    if (cfg_write) begin
      unique case (paddr[3])
        RegShapeRank: shape_rank_d = pwdata[CntW-1:0];
        RegDimSizes:  dim_sizes_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      RegShapeRank: prdata = DataW'(shape_rank_q);
      RegDimSizes:  prdata = dim_sizes_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_rank_q <= '0;
      dim_sizes_q  <= 64'h0101_0101_0101_0101;
    end else begin
      shape_rank_q <= shape_rank_d;
      dim_sizes_q  <= dim_sizes_d;
    end
  end

  ticc_ctrl #(
    .MAX_RANK(MAX_RANK)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .coordinate_count_i (coordinate_count_i),
    .shape_rank_i       (shape_rank_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cmd_o              (cmd)
  );

  ticc_dp u_dp (
    .clk_i                  (clk_i),
    .cmd_i                  (cmd),
    .dimension_sizes_i      (dim_sizes_q),
    .coordinates_in_i       (coordinates_in_i),
    .linear_index_in_i      (linear_index_in_i),
    .linear_index_out_o     (linear_index_out_o),
    .coordinates_out_o      (coordinates_out_o),
    .coordinate_count_out_o (coordinate_count_out_o)
  );

endmodule

/* dv/converter_checker.sv */
`timescale 1ns / 100ps

module converter_checker
  import ticc_pkg::*;
#(
  parameter int unsigned MaxRank = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             mode_i,
  input  logic [DataW-1:0] coordinates_in_i,
  input  logic [CntW-1:0]  coordinate_count_i,
  input  logic [DataW-1:0] linear_index_in_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [DataW-1:0] linear_index_out_i,
  input  logic [DataW-1:0] coordinates_out_i,
  input  logic [CntW-1:0]  coordinate_count_out_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [DataW-1:0] index;
    logic [DataW-1:0] coords;
    logic [CntW-1:0]  count;
  } conversion_t;

  conversion_t     expected_conversions_q[$];
  logic [CntW-1:0]  shape_rank_q;
  logic [DataW-1:0] dim_sizes_q;

  // Track the shape registers as the block sees them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_rank_q <= '0;
      dim_sizes_q  <= {8{8'h01}};
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == RegShapeRank) begin
        shape_rank_q <= pwdata[CntW-1:0];
      end else begin
        dim_sizes_q <= pwdata;
      end
    end
  end

  // Zero-sized dimensions count as size one.
  function automatic logic [DataW-1:0] dim_size(input int unsigned slot);
    logic [DimW-1:0] raw;
    raw = dim_sizes_q[slot*DimW +: DimW];
    return (raw == '0) ? DataW'(1) : DataW'(raw);
  endfunction

  function automatic conversion_t convert_item(input logic mode,
                                               input logic [DataW-1:0] coords,
                                               input logic [CntW-1:0] count,
                                               input logic [DataW-1:0] index);
    conversion_t      res;
    int unsigned      rank_eff;
    int unsigned      count_eff;
    int unsigned      used;
    logic [DataW-1:0] rest;
    logic [DataW-1:0] d;
    res       = '0;
    rank_eff  = (shape_rank_q > MaxRank) ? MaxRank : shape_rank_q;
    if (mode == ModeToIndex) begin
      count_eff = (count > MaxRank) ? MaxRank : count;
      used      = (rank_eff < count_eff) ? rank_eff : count_eff;
      // Horner fold, slowest used dimension first; wraps at 64 bits
      for (int i = int'(used) - 1; i >= 0; i--) begin
        res.index = res.index * dim_size(i) + DataW'(coords[i*DimW +: DimW]);
      end
    end else begin
      rest = index;
      for (int unsigned i = 0; i < rank_eff; i++) begin
        d = dim_size(i);
        res.coords[i*DimW +: DimW] = DimW'(rest % d);
        rest = rest / d;
      end
      res.count = CntW'(rank_eff);
    end
    return res;
  endfunction

  function automatic void report_field(input string field, input logic [DataW-1:0] want,
                                       input logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      fail_count_o++;
    end
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    conversion_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expected_conversions_q.insert(expected_conversions_q.size(),
                                      convert_item(mode_i, coordinates_in_i,
                                                   coordinate_count_i, linear_index_in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_conversions_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual index %h coords %h count %h",
                   $time, linear_index_out_i, coordinates_out_i, coordinate_count_out_i);
          fail_count_o++;
        end else begin
          want = expected_conversions_q.pop_front();
          report_field("linear_index_out", want.index, linear_index_out_i);
          report_field("coordinates_out", want.coords, coordinates_out_i);
          report_field("coordinate_count_out", DataW'(want.count),
                       DataW'(coordinate_count_out_i));
        end
      end
      pending_o = expected_conversions_q.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ticc_pkg::*;

  localparam int unsigned MaxRank     = 8;
  localparam int unsigned QuietLimit  = 10000;
  localparam int unsigned LongHold    = 1500;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseItems  = 113;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             mode_i;
  logic [DataW-1:0] coordinates_in_i;
  logic [CntW-1:0]  coordinate_count_i;
  logic [DataW-1:0] linear_index_in_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [DataW-1:0] linear_index_out_o;
  logic [DataW-1:0] coordinates_out_o;
  logic [CntW-1:0]  coordinate_count_out_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [3:0]       paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      items_sent;
  int unsigned      results_seen;
  int unsigned      burst_left;
  logic             long_hold_req;
  logic [CntW-1:0]  cfg_rank;
  logic [DataW-1:0] cfg_dims;

  tensor_index_coordinate_converter #(
    .MAX_RANK(MaxRank)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .mode_i                (mode_i),
    .coordinates_in_i      (coordinates_in_i),
    .coordinate_count_i    (coordinate_count_i),
    .linear_index_in_i     (linear_index_in_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .linear_index_out_o    (linear_index_out_o),
    .coordinates_out_o     (coordinates_out_o),
    .coordinate_count_out_o(coordinate_count_out_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  converter_checker #(
    .MaxRank(MaxRank)
  ) u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .mode_i                (mode_i),
    .coordinates_in_i      (coordinates_in_i),
    .coordinate_count_i    (coordinate_count_i),
    .linear_index_in_i     (linear_index_in_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .linear_index_out_i    (linear_index_out_o),
    .coordinates_out_i     (coordinates_out_o),
    .coordinate_count_out_i(coordinate_count_out_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .pready                (pready),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
    end
  end

  // Receiver: stall with a random percentage that is redrawn whenever its pattern runs out.
  initial begin
    int unsigned stall_pct;
    int unsigned pattern_left;
    out_stall_i  = 1'b0;
    pattern_left = 0;
    stall_pct    = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        // hold off long enough for the block to back up into its input
        out_stall_i = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        pattern_left = $urandom_range(50, 400);
      end
      pattern_left--;
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tensor_index_coordinate_converter test failed");
    $finish;
  end

  function automatic logic [DataW-1:0] cfg_dim(input int unsigned slot);
    logic [DimW-1:0] raw;
    raw = cfg_dims[slot*DimW +: DimW];
    return (raw == '0) ? DataW'(1) : DataW'(raw);
  endfunction

  // Number of elements in the configured shape.
  function automatic logic [DataW-1:0] shape_span();
    logic [DataW-1:0] span;
    int unsigned      rank_eff;
    span     = DataW'(1);
    rank_eff = (cfg_rank > MaxRank) ? MaxRank : cfg_rank;
    for (int unsigned i = 0; i < rank_eff; i++) begin
      span = span * cfg_dim(i);
    end
    return span;
  endfunction

  task automatic scramble_payload();
    mode_i             = 1'($urandom);
    coordinates_in_i   = {$urandom, $urandom};
    coordinate_count_i = CntW'($urandom);
    linear_index_in_i  = {$urandom, $urandom};
  endtask

  task automatic send_item(input logic mode, input logic [DataW-1:0] coords,
                           input logic [CntW-1:0] count, input logic [DataW-1:0] index);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        scramble_payload();
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i         = 1'b1;
    mode_i             = mode;
    coordinates_in_i   = coords;
    coordinate_count_i = count;
    linear_index_in_i  = index;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
  endtask

  task automatic write_register(input logic sel, input logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reshape only once every beat in flight has come out.
  task automatic load_shape(input logic [CntW-1:0] rank, input logic [DataW-1:0] dims);
    release_input();
    wait (results_seen == items_sent);
    write_register(RegShapeRank, DataW'(rank));
    write_register(RegDimSizes, dims);
    cfg_rank = rank;
    cfg_dims = dims;
  endtask

  task automatic send_random_item();
    logic             mode;
    logic [DataW-1:0] coords;
    logic [DataW-1:0] index;
    logic [DataW-1:0] span;
    logic [CntW-1:0]  count;
    int unsigned      pick;
    mode   = 1'($urandom);
    coords = {$urandom, $urandom};
    index  = {$urandom, $urandom};
    count  = CntW'($urandom);
    if (mode == ModeToIndex) begin
      if ($urandom_range(0, 9) < 7) begin
        for (int unsigned i = 0; i < MaxRank; i++) begin
          coords[i*DimW +: DimW] = DimW'($urandom_range(0, 32'(cfg_dim(i)) - 1));
        end
      end
      if ($urandom_range(0, 9) < 6) begin
        count = cfg_rank;
      end
    end else begin
      span = shape_span();
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        index = index % span;
      end else if (pick == 6) begin
        index = span - 1;
      end else if (pick == 7) begin
        index = span;
      end
    end
    send_item(mode, coords, count, index);
  endtask

  initial begin
    logic [DataW-1:0] dims;
    logic [CntW-1:0]  rank;
    int unsigned      sel;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = ModeToIndex;
    coordinates_in_i   = '0;
    coordinate_count_i = '0;
    linear_index_in_i  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    items_sent    = 0;
    results_seen  = 0;
    burst_left    = 0;
    long_hold_req = 1'b0;
    cfg_rank      = '0;
    cfg_dims      = {8{8'h01}};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Shape out of reset: rank zero, nothing to fold or split
    send_item(ModeToIndex, {8{8'h5A}}, 4'd8, {$urandom, $urandom});
    send_item(ModeToCoords, {8{8'hA5}}, 4'd3, {$urandom, $urandom});

    // Full rank, mixed sizes with a zero dimension
    load_shape(4'd8, 64'hFF00_07FF_0210_FF03);
    send_item(ModeToIndex, {8{8'hFF}}, 4'd8, {$urandom, $urandom});
    send_item(ModeToIndex, '0, 4'd8, {8{8'hFF}});
    send_item(ModeToIndex, {$urandom, $urandom}, 4'd0, {$urandom, $urandom});
    send_item(ModeToIndex, {$urandom, $urandom}, 4'd15, {$urandom, $urandom});
    send_item(ModeToIndex, {$urandom, $urandom}, 4'd9, {$urandom, $urandom});
    send_item(ModeToIndex, {$urandom, $urandom}, 4'd1, {$urandom, $urandom});
    send_item(ModeToIndex, 64'hFE00_06FE_010F_FE02, 4'd8, '0);
    send_item(ModeToCoords, {$urandom, $urandom}, 4'd0, '0);
    send_item(ModeToCoords, '0, 4'd15, {8{8'hFF}});
    send_item(ModeToCoords, {8{8'hFF}}, 4'd8, shape_span() - 1);
    send_item(ModeToCoords, {$urandom, $urandom}, 4'd1, shape_span());
    send_item(ModeToCoords, {$urandom, $urandom}, 4'd8, {$urandom, $urandom});

    // Largest shape
    load_shape(4'd8, {8{8'hFF}});
    send_item(ModeToIndex, {8{8'hFF}}, 4'd8, '0);
    send_item(ModeToCoords, '0, 4'd0, {8{8'hFF}});
    send_item(ModeToCoords, '0, 4'd0, shape_span() - 1);

    // Rank past the maximum, every dimension zero
    load_shape(4'd15, '0);
    send_item(ModeToIndex, {$urandom, $urandom}, 4'd8, '0);
    send_item(ModeToCoords, {8{8'hFF}}, 4'd15, {$urandom, $urandom});

    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        0: rank = 4'd8;
        1: rank = 4'd1;
        2: rank = 4'd15;
        3: rank = 4'd0;
        4, 5: rank = CntW'($urandom_range(2, 8));
        default: rank = CntW'($urandom_range(0, 15));
      endcase
      for (int unsigned i = 0; i < MaxRank; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          dims[i*DimW +: DimW] = '0;
        end else if (sel == 1) begin
          dims[i*DimW +: DimW] = '1;
        end else if (sel < 6) begin
          dims[i*DimW +: DimW] = DimW'($urandom_range(1, 6));
        end else begin
          dims[i*DimW +: DimW] = DimW'($urandom);
        end
      end
      load_shape(rank, dims);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (phase == 4 && n == 30) begin
          long_hold_req = 1'b1;
        end
        send_random_item();
      end
    end

    release_input();
    wait (results_seen == items_sent);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tensor_index_coordinate_converter test passed");
    end else begin
      $display("tensor_index_coordinate_converter test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ticc_pkg.sv
rtl/ticc_dp.sv
rtl/ticc_ctrl.sv
rtl/tensor_index_coordinate_converter.sv
dv/converter_checker.sv
dv/testbench.sv
